// ===== hw/rtl/itoc_pkg.sv =====
package itoc_pkg;

    localparam int CURRENT_BITS_DEF = 16;
    localparam int FRAC_BITS        = 16;
    localparam int LOG_STEPS        = 16;
    localparam int EXP_STEPS        = 16;
    localparam int DIV_STEPS        = 32;

    localparam logic [15:0] PICKUP_RST = 16'd5120;
    localparam logic [31:0] TMUL_RST   = 32'd983040;
    localparam logic [15:0] CEXP_RST   = 16'd6144;

    typedef enum logic [1:0] {
        REG_PICKUP = 2'd0,
        REG_TMUL   = 2'd1,
        REG_CEXP   = 2'd2
    } t_reg;

    // Per-item flags that travel with the data down the pipeline.
    typedef struct packed {
        logic       tripped;
        logic       zero;
        logic       sat;
        logic [5:0] shamt;
    } t_side;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(2^-k) in Q.30, built by repeated square roots from 2.0.
    function automatic logic [30:0] root_q30(input int k);
        logic [63:0] r;
        r = 64'd1 << 31;
        for (int i = 1; i <= k; i++) begin
            r = isqrt64(r << 30);
        end
        return r[30:0];
    endfunction

endpackage

// ===== hw/rtl/inverse_time_overcurrent_trip_top.sv =====
// Channel   Direction  Beat contents
// s (in)    slave      tdata[15:0] = current_sample
// m (out)   master     tdata[0] = tripped, tdata[32:1] = trip_delay, rest zero
// APB       slave      0x0 pickup_current, 0x4 time_multiplier, 0x8 curve_exponent
//
// One beat is accepted per cycle while the skid register is empty; each result passes
// through the input stage, 17 log2 stages, exponent multiply, 16 exp2 stages, two stages
// for the denominator and overflow check, 32 divider stages and the output register.
// Reset is synchronous and clears all valid bits; registers take their defaults.
// A skid register behind the output lets the pipeline take one more beat while
// a result waits; only when the skid is full does the whole pipeline hold.
module inverse_time_overcurrent_trip_top #(
    parameter int CURRENT_BITS = itoc_pkg::CURRENT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // current_sample
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // tripped, trip_delay[31:0], zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int W  = CURRENT_BITS;
    localparam int TW = $clog2(W);
    localparam int LW = TW + itoc_pkg::FRAC_BITS;
    localparam int PW = LW + 16;
    localparam int NW = PW - 28;

    logic [15:0] r_pickup;
    logic [31:0] r_tmul;
    logic [15:0] r_cexp;

    // Configuration port.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pickup <= itoc_pkg::PICKUP_RST;
            r_tmul   <= itoc_pkg::TMUL_RST;
            r_cexp   <= itoc_pkg::CEXP_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                itoc_pkg::REG_PICKUP: r_pickup <= pwdata[15:0];
                itoc_pkg::REG_TMUL:   r_tmul   <= pwdata;
                itoc_pkg::REG_CEXP:   r_cexp   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            itoc_pkg::REG_PICKUP: prdata = {16'd0, r_pickup};
            itoc_pkg::REG_TMUL:   prdata = r_tmul;
            itoc_pkg::REG_CEXP:   prdata = {16'd0, r_cexp};
            default:              prdata = '0;
        endcase
    end

    logic r_skid_vld;
    logic en;
    assign en         = !r_skid_vld;
    assign o_s_tready = en;

    // Input stage.
    logic              r_in_vld;
    itoc_pkg::t_side   r_in_side;
    logic [1:0][W-1:0] r_in_x;
    logic [W-1:0]      cur;
    logic [W-1:0]      ip;
    itoc_pkg::t_side   n_in_side;

    assign cur = W'(i_s_tdata);
    assign ip  = W'(r_pickup);

    always_comb begin
        n_in_side         = '0;
        n_in_side.tripped = cur > ip;
        n_in_side.zero    = (cur <= ip) || (ip == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (en) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_side <= n_in_side;
            r_in_x    <= {ip, cur};
        end
    end

    logic               l_vld;
    itoc_pkg::t_side    l_side;
    logic [1:0][LW-1:0] l_l;

    itoc_log2 #(.W(W)) u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_in_vld),
        .i_side  (r_in_side),
        .i_x     (r_in_x),
        .o_vld   (l_vld),
        .o_side  (l_side),
        .o_l     (l_l)
    );

    // Exponent stage: y = ((log2 I - log2 Ip) * alpha) >> 12.
    logic            r_y_vld;
    itoc_pkg::t_side r_y_side;
    logic [15:0]     r_y_frac;
    logic [LW-1:0]   d;
    logic [PW-1:0]   prod;
    logic [NW-1:0]   nint;
    itoc_pkg::t_side n_y_side;

    assign d    = l_l[0] - l_l[1];
    assign prod = PW'(d) * PW'(r_cexp);
    assign nint = prod[PW-1:28];

    always_comb begin
        n_y_side       = l_side;
        n_y_side.zero  = l_side.zero || (nint >= NW'(34));
        n_y_side.shamt = nint[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_vld <= 1'b0;
        end else if (en) begin
            r_y_vld <= l_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_y_side <= n_y_side;
            r_y_frac <= prod[27:12];
        end
    end

    logic            e_vld;
    itoc_pkg::t_side e_side;
    logic [30:0]     e_m;

    itoc_exp2 u_exp2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_y_vld),
        .i_side  (r_y_side),
        .i_frac  (r_y_frac),
        .o_vld   (e_vld),
        .o_side  (e_side),
        .o_m     (e_m)
    );

    // Denominator stage: P = m << n, D = P - 1.0.
    logic            r_d_vld;
    itoc_pkg::t_side r_d_side;
    logic [63:0]     r_d_den;
    logic [63:0]     pw;
    itoc_pkg::t_side n_d_side;

    assign pw = 64'(e_m) << e_side.shamt;

    always_comb begin
        n_d_side      = e_side;
        n_d_side.zero = e_side.zero || (pw <= (64'd1 << 30));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (en) begin
            r_d_vld <= e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_side <= n_d_side;
            r_d_den  <= pw - (64'd1 << 30);
        end
    end

    // Overflow check: the quotient of (K << 30) / D needs more than 32 bits
    // exactly when the dividend's top 30 bits already reach D.
    logic            r_s_vld;
    itoc_pkg::t_side r_s_side;
    logic [63:0]     r_s_den;
    logic [64:0]     r_s_rem;
    logic [31:0]     r_s_nlo;
    itoc_pkg::t_side n_s_side;

    always_comb begin
        n_s_side     = r_d_side;
        n_s_side.sat = (r_d_den[63:30] == '0) && (r_tmul[31:2] >= r_d_den[29:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else if (en) begin
            r_s_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s_side <= n_s_side;
            r_s_den  <= r_d_den;
            r_s_rem  <= 65'(r_tmul[31:2]);
            r_s_nlo  <= {r_tmul[1:0], 30'd0};
        end
    end

    logic            q_vld;
    itoc_pkg::t_side q_side;
    logic [31:0]     q_q;

    itoc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_s_vld),
        .i_side  (r_s_side),
        .i_den   (r_s_den),
        .i_rem   (r_s_rem),
        .i_nlo   (r_s_nlo),
        .o_vld   (q_vld),
        .o_side  (q_side),
        .o_q     (q_q)
    );

    logic [32:0] p_res;
    assign p_res = {q_side.zero ? 32'd0 : (q_side.sat ? 32'hFFFF_FFFF : q_q),
                    q_side.tripped};

    // Output register with skid.
    logic        r_out_vld;
    logic [32:0] r_out;
    logic [32:0] r_skid;
    logic        out_take;

    assign out_take = r_out_vld && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (out_take) r_skid_vld <= 1'b0;
        end else if (q_vld) begin
            if (!r_out_vld || out_take) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (out_take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (out_take) r_out <= r_skid;
        end else if (q_vld) begin
            if (!r_out_vld || out_take) begin
                r_out <= p_res;
            end else begin
                r_skid <= p_res;
            end
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {7'd0, r_out};

    a_skid_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid holds a result while the output register is empty");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && !i_m_tready) |=> (r_skid_vld && $stable(r_skid)))
        else $error("skid result lost while output stalled");

    a_no_trip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[0]) |-> (o_m_tdata[32:1] == 32'd0))
        else $error("nonzero delay without a trip");

    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && q_vld) |=> q_vld)
        else $error("pipeline advanced while skid was full");

endmodule

// ===== hw/rtl/itoc_log2.sv =====
module itoc_log2 #(
    parameter int W = itoc_pkg::CURRENT_BITS_DEF,
    localparam int TW = $clog2(W),
    localparam int LW = TW + itoc_pkg::FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_vld,
    input  itoc_pkg::t_side          i_side,
    input  logic [1:0][W-1:0]        i_x,
    output logic                     o_vld,
    output itoc_pkg::t_side          o_side,
    output logic [1:0][LW-1:0]       o_l
);
    localparam int NS = itoc_pkg::LOG_STEPS;

    logic                  r_vld  [0:NS];
    itoc_pkg::t_side       r_side [0:NS];
    logic [1:0][30:0]      r_m    [0:NS];
    logic [1:0][TW-1:0]    r_top  [0:NS];
    logic [1:0][NS-1:0]    r_f    [0:NS];

    logic [1:0][TW-1:0]    n_top;
    logic [1:0][30:0]      n_m;

    // Leading-one detect and normalization to Q1.30.
    always_comb begin
        logic [30:0] xe;
        logic [4:0]  sh;
        for (int l = 0; l < 2; l++) begin
            n_top[l] = '0;
            for (int i = 0; i < W; i++) begin
                if (i_x[l][i]) n_top[l] = TW'(i);
            end
            xe     = 31'(i_x[l]);
            sh     = 5'd30 - 5'(n_top[l]);
            n_m[l] = xe << sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_m[0]    <= n_m;
            r_top[0]  <= n_top;
            r_f[0]    <= '0;
        end
    end

    for (genvar k = 1; k <= NS; k++) begin : g_sq
        logic [1:0][30:0]   n_ms;
        logic [1:0][NS-1:0] n_fs;

        always_comb begin
            logic [61:0] sq;
            logic [31:0] t;
            for (int l = 0; l < 2; l++) begin
                sq      = 62'(r_m[k-1][l]) * 62'(r_m[k-1][l]);
                t       = sq[61:30];
                n_ms[l] = t[31] ? t[31:1] : t[30:0];
                n_fs[l] = {r_f[k-1][l][NS-2:0], t[31]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= r_side[k-1];
                r_m[k]    <= n_ms;
                r_top[k]  <= r_top[k-1];
                r_f[k]    <= n_fs;
            end
        end
    end

    assign o_vld  = r_vld[NS];
    assign o_side = r_side[NS];
    assign o_l[0] = {r_top[NS][0], r_f[NS][0]};
    assign o_l[1] = {r_top[NS][1], r_f[NS][1]};

endmodule

// ===== hw/rtl/itoc_exp2.sv =====
module itoc_exp2 (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  itoc_pkg::t_side i_side,
    input  logic [15:0]     i_frac,
    output logic            o_vld,
    output itoc_pkg::t_side o_side,
    output logic [30:0]     o_m
);
    localparam int NS = itoc_pkg::EXP_STEPS;

    logic            w_vld  [0:NS];
    itoc_pkg::t_side w_side [0:NS];
    logic [30:0]     w_m    [0:NS];
    logic [15:0]     w_fr   [0:NS];

    assign w_vld[0]  = i_vld;
    assign w_side[0] = i_side;
    assign w_m[0]    = 31'h4000_0000;
    assign w_fr[0]   = i_frac;

    for (genvar k = 1; k <= NS; k++) begin : g_mul
        localparam logic [30:0] RK = itoc_pkg::root_q30(k);
        logic [61:0]     prod;
        logic [30:0]     n_m;
        logic            r_vld;
        itoc_pkg::t_side r_side;
        logic [30:0]     r_m;
        logic [15:0]     r_fr;

        assign prod = 62'(w_m[k-1]) * 62'(RK);
        assign n_m  = w_fr[k-1][16-k] ? prod[60:30] : w_m[k-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side <= w_side[k-1];
                r_m    <= n_m;
                r_fr   <= w_fr[k-1];
            end
        end

        assign w_vld[k]  = r_vld;
        assign w_side[k] = r_side;
        assign w_m[k]    = r_m;
        assign w_fr[k]   = r_fr;
    end

    assign o_vld  = w_vld[NS];
    assign o_side = w_side[NS];
    assign o_m    = w_m[NS];

endmodule

// ===== hw/rtl/itoc_div.sv =====
module itoc_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  itoc_pkg::t_side i_side,
    input  logic [63:0]     i_den,
    input  logic [64:0]     i_rem,
    input  logic [31:0]     i_nlo,
    output logic            o_vld,
    output itoc_pkg::t_side o_side,
    output logic [31:0]     o_q
);
    localparam int NS = itoc_pkg::DIV_STEPS;

    logic            w_vld  [0:NS];
    itoc_pkg::t_side w_side [0:NS];
    logic [63:0]     w_den  [0:NS];
    logic [64:0]     w_rem  [0:NS];
    logic [31:0]     w_nlo  [0:NS];
    logic [31:0]     w_q    [0:NS];

    assign w_vld[0]  = i_vld;
    assign w_side[0] = i_side;
    assign w_den[0]  = i_den;
    assign w_rem[0]  = i_rem;
    assign w_nlo[0]  = i_nlo;
    assign w_q[0]    = '0;

    // One quotient bit per stage: shift in the next dividend bit, try a subtract.
    for (genvar k = 1; k <= NS; k++) begin : g_step
        logic [64:0]     rem2;
        logic            ge;
        logic            r_vld;
        itoc_pkg::t_side r_side;
        logic [63:0]     r_den;
        logic [64:0]     r_rem;
        logic [31:0]     r_nlo;
        logic [31:0]     r_q;

        assign rem2 = {w_rem[k-1][63:0], w_nlo[k-1][31]};
        assign ge   = rem2 >= {1'b0, w_den[k-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side <= w_side[k-1];
                r_den  <= w_den[k-1];
                r_rem  <= ge ? rem2 - {1'b0, w_den[k-1]} : rem2;
                r_nlo  <= {w_nlo[k-1][30:0], 1'b0};
                r_q    <= {w_q[k-1][30:0], ge};
            end
        end

        assign w_vld[k]  = r_vld;
        assign w_side[k] = r_side;
        assign w_den[k]  = r_den;
        assign w_rem[k]  = r_rem;
        assign w_nlo[k]  = r_nlo;
        assign w_q[k]    = r_q;
    end

    assign o_vld  = w_vld[NS];
    assign o_side = w_side[NS];
    assign o_q    = w_q[NS];

endmodule

// ===== tb/sv/itoc_delay_checker.sv =====
`timescale 1ns / 100ps

module itoc_delay_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_trip_count
);
    typedef struct packed {
        logic        tripped;
        logic [31:0] delay;
    } t_trip_result;

    logic [15:0] pickup;
    logic [31:0] tmul;
    logic [15:0] cexp;
    logic [63:0] roots [1:16];
    t_trip_result expected_q [$];

    function automatic logic [63:0] sqrt_floor(input logic [63:0] v_in);
        logic [63:0] v, r, b;
        v = v_in;
        r = 0;
        b = 64'd1 << 62;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Fixed-point log2: integer part from the top bit, fraction by squaring.
    function automatic logic [63:0] log2_fix(input logic [63:0] x);
        int top;
        logic [63:0] m, frac;
        top = 0;
        frac = 0;
        while (top < 63 && (x >> (top + 1)) != 0) top++;
        m = (top <= 30) ? (x << (30 - top)) : (x >> (top - 30));
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        return (64'(top) << 16) | frac;
    endfunction

    function automatic t_trip_result predict_result(input logic [15:0] cur);
        t_trip_result r;
        logic [63:0] y, n, m, p, den, q;
        r = '0;
        if (cur <= pickup) return r;
        r.tripped = 1'b1;
        if (pickup == 0) return r;
        y = ((log2_fix(cur) - log2_fix(pickup)) * cexp) >> 12;
        n = y >> 16;
        if (n >= 34) return r;
        m = 64'd1 << 30;
        for (int k = 1; k <= 16; k++)
            if (y[16-k]) m = (m * roots[k]) >> 30;
        p = m << n;
        if (p <= (64'd1 << 30)) return r;
        den = p - (64'd1 << 30);
        q = ({32'd0, tmul} << 30) / den;
        r.delay = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
        return r;
    endfunction

    initial begin
        logic [63:0] r;
        r = 64'd1 << 31;
        for (int k = 1; k <= 16; k++) begin
            r = sqrt_floor(r << 30);
            roots[k] = r;
        end
    end

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_trip_result exp_r, got;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            pickup <= itoc_pkg::PICKUP_RST;
            tmul   <= itoc_pkg::TMUL_RST;
            cexp   <= itoc_pkg::CEXP_RST;
            o_fail_count <= 0;
            o_trip_count <= 0;
            expected_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) expected_q.push_back(predict_result(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got.tripped = i_m_tdata[0];
                got.delay   = i_m_tdata[32:1];
                if (got.tripped) o_trip_count <= o_trip_count + 1;
                if (expected_q.size() == 0) begin
                    $error("result beat with nothing expected: %h", i_m_tdata);
                    errs++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got.tripped !== exp_r.tripped) begin
                        $error("tripped: expected %0d actual %0d", exp_r.tripped, got.tripped);
                        errs++;
                    end
                    if (got.delay !== exp_r.delay) begin
                        $error("trip_delay: expected %h actual %h", exp_r.delay, got.delay);
                        errs++;
                    end
                    if (i_m_tdata[39:33] !== 7'd0) begin
                        $error("pad: expected 0 actual %h", i_m_tdata[39:33]);
                        errs++;
                    end
                end
            end
            if (errs != 0) o_fail_count <= o_fail_count + errs;
            if (psel && penable && pwrite) begin
                case (paddr[3:2])
                    itoc_pkg::REG_PICKUP: pickup <= pwdata[15:0];
                    itoc_pkg::REG_TMUL:   tmul   <= pwdata;
                    itoc_pkg::REG_CEXP:   cexp   <= pwdata[15:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== tb/sv/inverse_time_overcurrent_trip_top_tb.sv =====
`timescale 1ns / 100ps

module inverse_time_overcurrent_trip_top_tb;
    localparam int LATENCY = 69;
    localparam int WATCHDOG_LIMIT = 4000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [15:0] s_tdata = 0;      // current_sample
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;          // tripped, trip_delay[31:0], zero pad
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [3:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending, trip_count;
    int          idle_cycles = 0;
    int          samples_sent = 0;
    bit          no_stall = 0;

    always #6 i_clk = ~i_clk;

    inverse_time_overcurrent_trip_top u_dut (
        .i_clk, .i_rst_n,
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata),
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    itoc_delay_checker u_chk (
        .i_clk, .i_rst_n,
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .psel, .penable, .pwrite, .paddr, .pwdata,
        .o_fail_count(fail_count), .o_pending(pending), .o_trip_count(trip_count)
    );

    always @(posedge i_clk) begin
        m_tready <= no_stall || ($urandom_range(99) >= 19);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(input itoc_pkg::t_reg idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic send_sample(input logic [15:0] cur);
        while (!no_stall && $urandom_range(99) < 19) begin
            s_tvalid <= 0;
            @(posedge i_clk);
        end
        s_tvalid <= 1;
        s_tdata <= cur;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        samples_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_current(input logic [15:0] ip);
        int sel;
        sel = $urandom_range(9);
        if (sel < 3) return 16'($urandom);
        if (sel < 5) return (ip > 0) ? 16'($urandom_range(ip)) : 16'd0;
        if (sel < 8) return (ip < 16'hFFFF) ? ip + 16'($urandom_range(1, 256)) : ip;
        return (ip < 16'hFFFF) ? 16'($urandom_range(32'(ip) + 1, 65535)) : ip;
    endfunction

    initial begin
        logic [15:0] ip;
        logic [15:0] directed [] = '{16'd0, 16'd1, 16'd5119, 16'd5120, 16'd5121,
                                     16'd5200, 16'd6000, 16'd10240, 16'd20480,
                                     16'd40000, 16'hFFFF, 16'h8000, 16'h5555, 16'hAAAA};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;

        // Reset settings first, then the special cases one phase at a time.
        foreach (directed[i]) send_sample(directed[i]);
        drain();
        write_reg(itoc_pkg::REG_CEXP, 0);
        send_sample(16'd6000); send_sample(16'hFFFF);
        drain();
        write_reg(itoc_pkg::REG_PICKUP, 0);
        write_reg(itoc_pkg::REG_CEXP, 16'hFFFF);
        write_reg(itoc_pkg::REG_TMUL, 32'hFFFF_FFFF);
        send_sample(0); send_sample(1); send_sample(16'hFFFF);
        drain();
        write_reg(itoc_pkg::REG_PICKUP, 1);
        send_sample(16'hFFFF); send_sample(2); send_sample(1);
        drain();
        write_reg(itoc_pkg::REG_PICKUP, 16'hFFFF);
        write_reg(itoc_pkg::REG_CEXP, 1);
        write_reg(itoc_pkg::REG_TMUL, 0);
        send_sample(16'hFFFF); send_sample(16'hFFFE);
        drain();
        write_reg(itoc_pkg::REG_PICKUP, 16'hFFFE);
        write_reg(itoc_pkg::REG_TMUL, 32'hFFFF_FFFF);
        send_sample(16'hFFFF);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            ip = (ph == 9) ? 16'd64 : 16'($urandom);
            if (ph == 4) ip = ip >> 8;
            write_reg(itoc_pkg::REG_PICKUP, ip);
            write_reg(itoc_pkg::REG_TMUL,
                      (ph % 3 == 0) ? $urandom : $urandom_range(32'h10_0000));
            write_reg(itoc_pkg::REG_CEXP, (ph == 1) ? 16'hFFFF : 16'($urandom));
            no_stall = (ph == 5);
            for (int i = 0; i < 153; i++) send_sample(rand_current(ip));
            drain();
        end
        no_stall = 0;

        $display("Ran %0d current samples over 16 register settings; %0d trips seen.",
                 samples_sent, trip_count);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/itoc_pkg.sv
hw/rtl/itoc_log2.sv
hw/rtl/itoc_exp2.sv
hw/rtl/itoc_div.sv
hw/rtl/inverse_time_overcurrent_trip_top.sv
tb/sv/itoc_delay_checker.sv
tb/sv/inverse_time_overcurrent_trip_top_tb.sv
